// File: design/fomr_pkg.sv
// ----------------------------------------------------------------------------
// fomr_pkg
// Shared sizes, codes and helpers of the fanout overwrite message ring engine.
// ----------------------------------------------------------------------------
package fomr_pkg;

    // sizes of the engine
    localparam int MESSAGE_BYTES = 64;
    localparam int MAX_HISTORY   = 8;
    localparam int SUBSCRIBERS   = 4;
    localparam int NUM_RINGS     = 4;
    localparam int RING_SLOTS    = MAX_HISTORY + 1;

    localparam int SLOT_W   = $clog2(RING_SLOTS);
    localparam int IDX_W    = $clog2(MESSAGE_BYTES);
    localparam int CNT_W    = $clog2(MESSAGE_BYTES + 1);
    localparam int BYTE_AW  = $clog2(RING_SLOTS * MESSAGE_BYTES);
    localparam int HIST_W   = 4;
    localparam int SUB_W    = 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 4;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 16;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HIST_0 = 3'd1;

    // input word kind
    localparam logic ACT_PUBLISH = 1'b0;
    localparam logic ACT_FETCH   = 1'b1;

    // result status codes
    localparam logic [1:0] STATUS_PUBLISHED = 2'd0;
    localparam logic [1:0] STATUS_REJECTED  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY     = 2'd2;
    localparam logic [1:0] STATUS_DATA      = 2'd3;

    // output register source select
    localparam logic [1:0] OUT_PUB   = 2'd0;
    localparam logic [1:0] OUT_EMPTY = 2'd1;
    localparam logic [1:0] OUT_DATA  = 2'd2;

    // controller to datapath commands
    typedef struct packed {
        logic       pub_wr;
        logic       fetch_start;
        logic       rd_first;
        logic       len_latch;
        logic       byte_adv;
        logic       out_load;
        logic [1:0] out_sel;
    } cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic empty;
        logic len_ok;
        logic byte_last;
    } stat_t;

    // highest slot index of a ring for a given history length
    function automatic logic [SLOT_W-1:0] last_slot(input logic [HIST_W-1:0] hist);
        logic [SLOT_W-1:0] res;
        if (hist == '0)
            res = SLOT_W'(1);
        else if (hist > HIST_W'(MAX_HISTORY))
            res = SLOT_W'(MAX_HISTORY);
        else
            res = SLOT_W'(hist);
        return res;
    endfunction

    // ring index advance with wrap
    function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] idx,
                                                    input logic [HIST_W-1:0] hist);
        logic [SLOT_W-1:0] res;
        if (idx == last_slot(hist))
            res = '0;
        else
            res = idx + 1'b1;
        return res;
    endfunction

    // byte store address of one slot position
    function automatic logic [BYTE_AW-1:0] byte_addr(input logic [SLOT_W-1:0] slot,
                                                     input logic [IDX_W-1:0] idx);
        return BYTE_AW'(slot) * BYTE_AW'(MESSAGE_BYTES) + BYTE_AW'(idx);
    endfunction

endpackage

// File: design/fomr_ram.sv
// ----------------------------------------------------------------------------
// fomr_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module fomr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // registered read, holds when not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: design/fomr_datapath.sv
// ----------------------------------------------------------------------------
// fomr_datapath
// Ring pointers, message assembly, byte and length stores and result register.
// ----------------------------------------------------------------------------
module fomr_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  fomr_pkg::cmd_t                cmd,
    output fomr_pkg::stat_t               stat,
    input  logic [7:0]                    in_byte,
    input  logic [fomr_pkg::SUB_W-1:0]    in_sub,
    input  logic                          in_last,
    input  logic                          cfg_we,
    input  logic [fomr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [fomr_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic [1:0]                    out_status,
    output logic [7:0]                    out_byte,
    output logic                          out_last,
    output logic [fomr_pkg::CNT_W-1:0]    out_len
);
    import fomr_pkg::*;

    // configuration
    logic [NUM_RINGS-1:0] enable_reg;
    logic [HIST_W-1:0]    hist_reg [NUM_RINGS];

    // ring pointers
    logic [SLOT_W-1:0] head_reg [NUM_RINGS];
    logic [SLOT_W-1:0] head_next [NUM_RINGS];
    logic [SLOT_W-1:0] tail_reg [NUM_RINGS];
    logic [SLOT_W-1:0] tail_next [NUM_RINGS];

    // message being published
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             overflow_reg;
    logic             overflow_next;

    // fetch context
    logic [SUB_W-1:0]  fsub_reg;
    logic [SLOT_W-1:0] fslot_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [CNT_W-1:0]  len_reg;

    // result register
    logic [1:0]       status_reg;
    logic [7:0]       byte_reg;
    logic             last_reg;
    logic [CNT_W-1:0] olen_reg;

    // store ports
    logic [NUM_RINGS-1:0] active;
    logic                 has_room;
    logic                 rejected;
    logic                 commit;
    logic [CNT_W-1:0]     commit_len;
    logic                 byte_re;
    logic [BYTE_AW-1:0]   byte_raddr;
    logic [7:0]           byte_rdata [NUM_RINGS];
    logic [CNT_W-1:0]     len_rdata  [NUM_RINGS];
    logic [7:0]           sel_byte;
    logic [CNT_W-1:0]     sel_len;

    assign has_room   = count_reg < CNT_W'(MESSAGE_BYTES);
    assign rejected   = overflow_reg || !has_room;
    assign commit     = cmd.pub_wr && in_last && !rejected;
    assign commit_len = count_reg + 1'b1;

    assign sel_byte = byte_rdata[fsub_reg];
    assign sel_len  = len_rdata[fsub_reg];

    // status to the controller
    assign stat.empty     = (int'(in_sub) >= SUBSCRIBERS) || (head_reg[in_sub] == tail_reg[in_sub]);
    assign stat.len_ok    = (sel_len != '0) && (sel_len <= CNT_W'(MESSAGE_BYTES));
    assign stat.byte_last = (CNT_W'(idx_reg) + 1'b1) == len_reg;

    // byte read address: first byte of the slot, or the one after the current
    assign byte_re    = cmd.rd_first || (cmd.byte_adv && !stat.byte_last);
    assign byte_raddr = cmd.rd_first ? byte_addr(fslot_reg, '0)
                                     : byte_addr(fslot_reg, idx_reg + 1'b1);

    // per ring stores
    for (genvar g = 0; g < NUM_RINGS; g++)
    begin : g_ring
        assign active[g] = (g < SUBSCRIBERS) && enable_reg[g];

        fomr_ram #(
            .WIDTH (8),
            .DEPTH (RING_SLOTS * MESSAGE_BYTES)
        ) u_bytes (
            .clk   (clk),
            .we    (cmd.pub_wr && active[g] && has_room),
            .waddr (byte_addr(tail_reg[g], count_reg[IDX_W-1:0])),
            .wdata (in_byte),
            .re    (byte_re),
            .raddr (byte_raddr),
            .rdata (byte_rdata[g])
        );

        fomr_ram #(
            .WIDTH (CNT_W),
            .DEPTH (RING_SLOTS)
        ) u_lens (
            .clk   (clk),
            .we    (commit && active[g]),
            .waddr (tail_reg[g]),
            .wdata (commit_len),
            .re    (cmd.rd_first),
            .raddr (fslot_reg),
            .rdata (len_rdata[g])
        );
    end

    // pointer next values
    always_comb
    begin
        for (int s = 0; s < NUM_RINGS; s++)
        begin
            head_next[s] = head_reg[s];
            tail_next[s] = tail_reg[s];
            if (commit && active[s])
            begin
                tail_next[s] = next_slot(tail_reg[s], hist_reg[s]);
                if (next_slot(tail_reg[s], hist_reg[s]) == head_reg[s])
                begin
                    head_next[s] = next_slot(head_reg[s], hist_reg[s]);
                end
            end
            if (cmd.fetch_start && (in_sub == SUB_W'(s)))
            begin
                head_next[s] = next_slot(head_reg[s], hist_reg[s]);
            end
            if (cfg_we && (cfg_index == REG_HIST_0 + CFG_IDX_W'(s)))
            begin
                head_next[s] = '0;
                tail_next[s] = '0;
            end
        end
    end

    // message count next values
    always_comb
    begin
        count_next    = count_reg;
        overflow_next = overflow_reg;
        if (cmd.pub_wr)
        begin
            priority if (in_last)
            begin
                count_next    = '0;
                overflow_next = 1'b0;
            end
            else if (has_room)
            begin
                count_next = count_reg + 1'b1;
            end
            else
            begin
                overflow_next = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg   <= '0;
            count_reg    <= '0;
            overflow_reg <= 1'b0;
            for (int s = 0; s < NUM_RINGS; s++)
            begin
                hist_reg[s] <= HIST_W'(1);
                head_reg[s] <= '0;
                tail_reg[s] <= '0;
            end
        end
        else
        begin
            count_reg    <= count_next;
            overflow_reg <= overflow_next;
            for (int s = 0; s < NUM_RINGS; s++)
            begin
                head_reg[s] <= head_next[s];
                tail_reg[s] <= tail_next[s];
                if (cfg_we && (cfg_index == REG_HIST_0 + CFG_IDX_W'(s)))
                begin
                    hist_reg[s] <= HIST_W'(cfg_data);
                end
            end
            if (cfg_we && (cfg_index == REG_ENABLE))
            begin
                enable_reg <= NUM_RINGS'(cfg_data);
            end
        end
    end

    // fetch context
    always_ff @(posedge clk)
    begin
        if (cmd.fetch_start)
        begin
            fsub_reg  <= in_sub;
            fslot_reg <= head_reg[in_sub];
            idx_reg   <= '0;
        end
        else if (cmd.byte_adv)
        begin
            idx_reg <= idx_reg + 1'b1;
        end
        if (cmd.len_latch)
        begin
            len_reg <= sel_len;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            unique case (cmd.out_sel)
                OUT_PUB:
                begin
                    status_reg <= rejected ? STATUS_REJECTED : STATUS_PUBLISHED;
                    byte_reg   <= '0;
                    last_reg   <= 1'b1;
                    olen_reg   <= rejected ? '0 : commit_len;
                end
                OUT_DATA:
                begin
                    status_reg <= STATUS_DATA;
                    byte_reg   <= sel_byte;
                    last_reg   <= stat.byte_last;
                    olen_reg   <= len_reg;
                end
                default:
                begin
                    status_reg <= STATUS_EMPTY;
                    byte_reg   <= '0;
                    last_reg   <= 1'b1;
                    olen_reg   <= '0;
                end
            endcase
        end
    end

    assign out_status = status_reg;
    assign out_byte   = byte_reg;
    assign out_last   = last_reg;
    assign out_len    = olen_reg;

endmodule

// File: design/fomr_ctrl.sv
// ----------------------------------------------------------------------------
// fomr_ctrl
// Sequencer for publish and fetch words and the result handshake.
// ----------------------------------------------------------------------------
module fomr_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic            in_action,
    input  logic            in_last,
    output logic            m_tvalid,
    input  logic            m_tready,
    input  fomr_pkg::stat_t stat,
    output fomr_pkg::cmd_t  cmd
);
    import fomr_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_RDLEN  = 2'd1;
    localparam logic [1:0] S_CHKLEN = 2'd2;
    localparam logic [1:0] S_BYTE   = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;
    logic       accept;

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;

    // command decode and next state
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    priority if (in_action == ACT_PUBLISH)
                    begin
                        cmd.pub_wr = 1'b1;
                        if (in_last)
                        begin
                            cmd.out_load = 1'b1;
                            cmd.out_sel  = OUT_PUB;
                        end
                    end
                    else if (stat.empty)
                    begin
                        cmd.out_load = 1'b1;
                        cmd.out_sel  = OUT_EMPTY;
                    end
                    else
                    begin
                        cmd.fetch_start = 1'b1;
                        state_next      = S_RDLEN;
                    end
                end
            end
            S_RDLEN:
            begin
                cmd.rd_first = 1'b1;
                state_next   = S_CHKLEN;
            end
            S_CHKLEN:
            begin
                cmd.len_latch = 1'b1;
                if (stat.len_ok)
                begin
                    state_next = S_BYTE;
                end
                else
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = OUT_EMPTY;
                    state_next   = S_IDLE;
                end
            end
            S_BYTE:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = OUT_DATA;
                    cmd.byte_adv = 1'b1;
                    if (stat.byte_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
        endcase
    end

    // result valid flag
    always_comb
    begin
        priority if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;

    // checks
    a_fetch_reads: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fetch_start |=> state_reg == S_RDLEN)
        else $error("fetch start did not go to length read");

    a_rdlen_then_check: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_RDLEN |=> state_reg == S_CHKLEN)
        else $error("length read not followed by length check");

    a_check_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CHKLEN |-> !out_valid_reg)
        else $error("result register busy at length check");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || m_tready))
        else $error("pending result overwritten");

endmodule

// File: design/fanout_overwrite_message_rings_unit.sv
// ----------------------------------------------------------------------------
// fanout_overwrite_message_rings_unit
// Publish/fetch engine for one topic fanning messages out to subscriber rings.
// ----------------------------------------------------------------------------
//  channel | direction | contents
//  s_*     | in        | publish byte or fetch request, tlast marks last byte
//  m_*     | out       | status result or fetched data byte
//  cfg_*   | in        | register write, no read-back
//
//  a published byte is taken while idle; the last byte's status follows in the next cycle
//  a fetch reads the slot length in its start, length read and length check steps, then
//  one byte per cycle unless the result stalls, paced by the registered read of the byte store
//  an empty fetch answers in the next cycle
//  reset empties all rings at once; stores need no clearing pass
//  a stalled result holds the block from taking a new word
// ----------------------------------------------------------------------------
module fanout_overwrite_message_rings_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [fomr_pkg::IN_TDATA_W-1:0]    s_tdata,   // pub_byte[7:0], subscriber[9:8]
    input  logic                               s_tuser,   // action
    input  logic                               s_tlast,   // pub_last
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [fomr_pkg::OUT_TDATA_W-1:0]   m_tdata,   // out_byte[7:0], message_len[14:8]
    output logic [1:0]                         m_tuser,   // status
    output logic                               m_tlast,   // out_last
    input  logic                               cfg_we,
    input  logic [fomr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [fomr_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import fomr_pkg::*;

    cmd_t             cmd;
    stat_t            stat;
    logic [7:0]       out_byte;
    logic [CNT_W-1:0] out_len;

    fomr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .in_action (s_tuser),
        .in_last   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    fomr_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .in_byte    (s_tdata[7:0]),
        .in_sub     (s_tdata[8 +: SUB_W]),
        .in_last    (s_tlast),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .out_status (m_tuser),
        .out_byte   (out_byte),
        .out_last   (m_tlast),
        .out_len    (out_len)
    );

    // pack result word
    assign m_tdata = {{(OUT_TDATA_W - 8 - CNT_W){1'b0}}, out_len, out_byte};

endmodule
